// ----- rtl/dhfk_pkg.sv -----
// Package for the DH forward kinematics core: formats, CORDIC angle table, helpers.
// No dependencies.
`default_nettype none
package dhfk_pkg;

    localparam int TABLE_LEN = 24;
    localparam logic signed [15:0] PI_Q13 = 16'sd25736;
    localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;
    localparam logic signed [31:0] PI_Z = 32'sd52707179;
    localparam logic signed [39:0] GAIN_Q30 = 40'sd652032875;
    localparam logic signed [17:0] ONE_Q16 = 18'sd65536;

    // Link item as it sits in the queue.
    typedef struct packed {
        logic signed [15:0] theta;
        logic signed [15:0] alpha;
        logic signed [23:0] len;
        logic signed [23:0] ofs;
        logic               last;
    } t_link;

    // CORDIC angle table, rad * 2^24.
    function automatic logic signed [31:0] atan_z(input logic [4:0] i);
        logic signed [31:0] v;
        begin
            case (i)
                5'd0: v = 32'sd13176795;
                5'd1: v = 32'sd7778716;
                5'd2: v = 32'sd4110060;
                5'd3: v = 32'sd2086331;
                5'd4: v = 32'sd1047214;
                5'd5: v = 32'sd524117;
                5'd6: v = 32'sd262123;
                5'd7: v = 32'sd131069;
                default: v = (i < 5'd24) ? (32'sd65536 >>> (i - 5'd8)) : 32'sd0;
            endcase
            return v;
        end
    endfunction

endpackage
`default_nettype wire

// ----- rtl/dhfk_queue.sv -----
// Two-entry link queue between the front (input port) and the back (kinematics engine).
// Depends on dhfk_pkg.
`default_nettype none
module dhfk_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  dhfk_pkg::t_link  i_link,
    output logic             o_valid,
    input  wire              i_ready,
    output dhfk_pkg::t_link  o_link
);
    dhfk_pkg::t_link r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_link  = r_mem[r_rp];

    // Storage holds no reset.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_mem[r_wp] <= i_link;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_valid && o_ready) r_wp <= ~r_wp;
            if (o_valid && i_ready) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_valid && o_ready} - {1'b0, o_valid && i_ready};
        end
    end
endmodule
`default_nettype wire

// ----- rtl/dhfk_cordic.sv -----
// Shared iterative CORDIC: rotation mode (sin/cos) and vectoring mode (atan2),
// one micro-rotation per cycle. Depends on dhfk_pkg.
`default_nettype none
module dhfk_cordic #(
    parameter int STEPS = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire                 i_vec,
    input  wire signed [15:0]   i_ang,
    input  wire signed [47:0]   i_x,
    input  wire signed [47:0]   i_y,
    output logic                o_done,
    output logic signed [17:0]  o_cos,
    output logic signed [17:0]  o_sin,
    output logic signed [15:0]  o_ang
);
    localparam int NS = (STEPS < dhfk_pkg::TABLE_LEN) ? STEPS : dhfk_pkg::TABLE_LEN;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN} t_state;
    t_state r_state;
    logic r_vec, r_neg;
    logic [4:0] r_i;
    logic signed [49:0] r_x, r_y;
    logic signed [33:0] r_z;

    logic signed [49:0] w_xs, w_ys, w_xr, w_yr;
    logic signed [16:0] w_af;
    logic signed [33:0] w_zr;
    logic signed [35:0] w_cr, w_sr;
    logic signed [17:0] w_ang;

    always_comb begin
        w_xs = r_x >>> r_i;
        w_ys = r_y >>> r_i;
        w_af = {i_ang[15], i_ang};
        w_cr = 36'((r_x + 50'sd8192) >>> 14);
        w_sr = 36'((r_y + 50'sd8192) >>> 14);
        w_zr = (r_z + 34'sd1024) >>> 11;
        w_ang = (w_zr > 34'sd25736) ? 18'sd25736 :
                (w_zr < -34'sd25736) ? -18'sd25736 : w_zr[17:0];
        w_xr = (w_cr > 36'sd65536) ? 50'sd65536 : (w_cr < -36'sd65536) ? -50'sd65536
             : {{14{w_cr[35]}}, w_cr};
        w_yr = (w_sr > 36'sd65536) ? 50'sd65536 : (w_sr < -36'sd65536) ? -50'sd65536
             : {{14{w_sr[35]}}, w_sr};
    end

    // Sequencer and datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_vec <= i_vec;
                        r_i <= 5'd0;
                        r_state <= S_RUN;
                        if (i_vec) begin
                            r_neg <= 1'b0;
                            if (i_x < 0) begin
                                r_x <= -{{2{i_x[47]}}, i_x};
                                r_y <= -{{2{i_y[47]}}, i_y};
                                r_z <= (i_y >= 0) ? 34'(dhfk_pkg::PI_Z) : -34'(dhfk_pkg::PI_Z);
                            end else begin
                                r_x <= {{2{i_x[47]}}, i_x};
                                r_y <= {{2{i_y[47]}}, i_y};
                                r_z <= '0;
                            end
                            if (i_x == 0 && i_y == 0) begin
                                r_z <= '0;
                                r_state <= S_FIN;
                            end
                        end else begin
                            r_x <= 50'(dhfk_pkg::GAIN_Q30);
                            r_y <= '0;
                            if (w_af > 17'(dhfk_pkg::HALF_PI_Q13)) begin
                                r_neg <= 1'b1;
                                r_z <= 34'(w_af - 17'(dhfk_pkg::PI_Q13)) <<< 11;
                            end else if (w_af < -17'(dhfk_pkg::HALF_PI_Q13)) begin
                                r_neg <= 1'b1;
                                r_z <= 34'(w_af + 17'(dhfk_pkg::PI_Q13)) <<< 11;
                            end else begin
                                r_neg <= 1'b0;
                                r_z <= 34'(w_af) <<< 11;
                            end
                        end
                    end
                end
                S_RUN: begin
                    if (r_vec && r_y == 0) begin
                        r_state <= S_FIN;
                    end else begin
                        if (r_vec ? (r_y > 0) : (r_z >= 0)) begin
                            r_x <= r_vec ? r_x + w_ys : r_x - w_ys;
                            r_y <= r_vec ? r_y - w_xs : r_y + w_xs;
                            r_z <= r_vec ? r_z + 34'(dhfk_pkg::atan_z(r_i))
                                         : r_z - 34'(dhfk_pkg::atan_z(r_i));
                        end else begin
                            r_x <= r_vec ? r_x - w_ys : r_x + w_ys;
                            r_y <= r_vec ? r_y + w_xs : r_y - w_xs;
                            r_z <= r_vec ? r_z - 34'(dhfk_pkg::atan_z(r_i))
                                         : r_z + 34'(dhfk_pkg::atan_z(r_i));
                        end
                        r_i <= r_i + 5'd1;
                        if (r_i == 5'(NS - 1)) r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    o_done <= 1'b1;
                    o_ang <= w_ang[15:0];
                    o_cos <= r_neg ? -w_xr[17:0] : w_xr[17:0];
                    o_sin <= r_neg ? -w_yr[17:0] : w_yr[17:0];
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- rtl/dhfk_engine.sv -----
// Back end: per-link transform product with one shared multiplier, then ZYZ Euler
// extraction on the last link. Depends on dhfk_pkg and dhfk_cordic.
`default_nettype none
module dhfk_engine #(
    parameter int STEPS = 16
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  dhfk_pkg::t_link  i_link,
    output logic             o_valid,
    input  wire              i_ready,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z,
    output logic signed [14:0] o_euler_first,
    output logic signed [15:0] o_euler_second,
    output logic signed [15:0] o_euler_third,
    output logic             o_saturated
);
    typedef enum logic [4:0] {
        S_IDLE, S_CT, S_CTW, S_CA, S_CAW, S_L, S_MR, S_MT, S_WB, S_E1, S_E1W,
        S_C1, S_C1W, S_P2, S_E2, S_E2W, S_P3, S_E3, S_E3W, S_OUT
    } t_state;
    t_state r_state;

    dhfk_pkg::t_link r_lk;
    logic signed [17:0] r_ct, r_st, r_ca, r_sa, r_c1, r_s1;
    logic signed [17:0] r_rot [9];
    logic signed [17:0] r_nr [9];
    logic signed [17:0] r_l [9];
    logic signed [31:0] r_tr [3];
    logic signed [31:0] r_pl [3];
    logic signed [31:0] r_np [3];
    logic r_ovf;
    logic [3:0] r_j;
    logic [1:0] r_k;
    logic signed [63:0] r_acc;
    logic signed [15:0] r_e1, r_e2, r_e3;
    logic signed [63:0] r_ya, r_xa;

    // Shared multiplier operands.
    logic signed [31:0] w_ma;
    logic signed [31:0] w_mb;
    logic signed [63:0] w_prod;
    logic [3:0] w_ri, w_li;
    logic [1:0] w_row, w_col;

    always_comb begin
        w_row = (r_j >= 4'd6) ? 2'd2 : ((r_j >= 4'd3) ? 2'd1 : 2'd0);
        w_col = 2'(r_j - 4'(w_row) * 4'd3);
        w_ri  = 4'(w_row) * 4'd3 + 4'(r_k);
        w_li  = 4'(r_k) * 4'd3 + 4'(w_col);
        w_ma  = 32'(r_rot[w_ri]);
        w_mb  = (r_state == S_MT) ? r_pl[r_k] : 32'(r_l[w_li]);
        w_prod = 64'(w_ma) * 64'(w_mb);
    end

    // CORDIC control.
    logic c_start, c_vec, c_done;
    logic signed [15:0] c_ang, c_out_ang;
    logic signed [47:0] c_x, c_y;
    logic signed [17:0] c_cos, c_sin;

    always_comb begin
        c_start = 1'b0;
        c_vec = 1'b0;
        c_ang = r_lk.theta;
        c_x = r_xa[47:0];
        c_y = r_ya[47:0];
        case (r_state)
            S_CT: c_start = 1'b1;
            S_CA: begin c_start = 1'b1; c_ang = r_lk.alpha; end
            S_C1: begin c_start = 1'b1; c_ang = r_e1; end
            S_E1, S_E2, S_E3: begin c_start = 1'b1; c_vec = 1'b1; end
            default: ;
        endcase
    end

    dhfk_cordic #(.STEPS(STEPS)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(c_start), .i_vec(c_vec),
        .i_ang(c_ang), .i_x(c_x), .i_y(c_y), .o_done(c_done),
        .o_cos(c_cos), .o_sin(c_sin), .o_ang(c_out_ang)
    );

    assign o_ready = (r_state == S_IDLE);

    function automatic logic signed [17:0] rq(input logic signed [35:0] p);
        logic signed [35:0] t;
        begin
            t = (p + 36'sd32768) >>> 16;
            return t[17:0];
        end
    endfunction

    // Main sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
            r_ovf <= 1'b0;
            for (int i = 0; i < 9; i++) begin
                r_rot[i] <= (i % 4 == 0) ? dhfk_pkg::ONE_Q16 : 18'sd0;
            end
            for (int i = 0; i < 3; i++) r_tr[i] <= '0;
        end else begin
            if (o_valid && i_ready && r_state != S_OUT) o_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (i_valid) begin r_lk <= i_link; r_state <= S_CT; end
                S_CT: r_state <= S_CTW;
                S_CTW: if (c_done) begin
                    r_ct <= c_cos; r_st <= c_sin; r_state <= S_CA;
                end
                S_CA: r_state <= S_CAW;
                S_CAW: if (c_done) begin
                    r_ca <= c_cos; r_sa <= c_sin; r_state <= S_L;
                end
                S_L: begin
                    r_l[0] <= r_ct;
                    r_l[1] <= rq(-(36'(r_st) * 36'(r_ca)));
                    r_l[2] <= rq(36'(r_st) * 36'(r_sa));
                    r_l[3] <= r_st;
                    r_l[4] <= rq(36'(r_ct) * 36'(r_ca));
                    r_l[5] <= rq(-(36'(r_ct) * 36'(r_sa)));
                    r_l[6] <= '0;
                    r_l[7] <= r_sa;
                    r_l[8] <= r_ca;
                    r_pl[0] <= 32'((64'(r_lk.len) * 64'(r_ct) + 64'sd32768) >>> 16);
                    r_pl[1] <= 32'((64'(r_lk.len) * 64'(r_st) + 64'sd32768) >>> 16);
                    r_pl[2] <= 32'(r_lk.ofs);
                    r_j <= '0; r_k <= '0; r_acc <= '0;
                    r_state <= S_MR;
                end
                // One product per cycle into the accumulator.
                S_MR: begin
                    if (r_k == 2'd2) begin
                        r_acc <= '0;
                        r_k <= '0;
                        if ((r_acc + w_prod + 64'sd32768) >>> 16 > 64'sd131071)
                            r_nr[r_j] <= 18'sd131071;
                        else if ((r_acc + w_prod + 64'sd32768) >>> 16 < -64'sd131072)
                            r_nr[r_j] <= -18'sd131072;
                        else
                            r_nr[r_j] <= 18'((r_acc + w_prod + 64'sd32768) >>> 16);
                        if (r_j == 4'd8) begin
                            r_j <= '0;
                            r_acc <= 64'(r_tr[0]) <<< 16;
                            r_state <= S_MT;
                        end else begin
                            r_j <= r_j + 4'd1;
                        end
                    end else begin
                        r_acc <= r_acc + w_prod;
                        r_k <= r_k + 2'd1;
                    end
                end
                S_MT: begin
                    // Translation rows use r_j itself as row base (j = 0, 3, 6).
                    if (r_k == 2'd2) begin
                        r_k <= '0;
                        if ((r_acc + w_prod + 64'sd32768) >>> 16 > 64'sd2147483647) begin
                            r_np[w_row] <= 32'sh7fffffff; r_ovf <= 1'b1;
                        end else if ((r_acc + w_prod + 64'sd32768) >>> 16
                                     < -64'sd2147483648) begin
                            r_np[w_row] <= 32'sh80000000; r_ovf <= 1'b1;
                        end else begin
                            r_np[w_row] <= 32'((r_acc + w_prod + 64'sd32768) >>> 16);
                        end
                        if (r_j == 4'd6) begin
                            r_state <= S_WB;
                        end else begin
                            r_j <= r_j + 4'd3;
                            r_acc <= 64'(r_tr[w_row + 2'd1]) <<< 16;
                        end
                    end else begin
                        r_acc <= r_acc + w_prod;
                        r_k <= r_k + 2'd1;
                    end
                end
                S_WB: begin
                    for (int i = 0; i < 9; i++) r_rot[i] <= r_nr[i];
                    for (int i = 0; i < 3; i++) r_tr[i] <= r_np[i];
                    r_ya <= 64'(r_nr[5]) <<< 16;
                    r_xa <= 64'(r_nr[2]) <<< 16;
                    r_state <= r_lk.last ? S_E1 : S_IDLE;
                end
                S_E1: r_state <= S_E1W;
                S_E1W: if (c_done) begin
                    if (c_out_ang > dhfk_pkg::HALF_PI_Q13)
                        r_e1 <= c_out_ang - dhfk_pkg::PI_Q13;
                    else if (c_out_ang < -dhfk_pkg::HALF_PI_Q13)
                        r_e1 <= c_out_ang + dhfk_pkg::PI_Q13;
                    else
                        r_e1 <= c_out_ang;
                    r_state <= S_C1;
                end
                S_C1: r_state <= S_C1W;
                S_C1W: if (c_done) begin
                    r_c1 <= c_cos; r_s1 <= c_sin; r_state <= S_P2;
                end
                S_P2: begin
                    r_ya <= 64'(r_nr[2]) * 64'(r_c1) + 64'(r_nr[5]) * 64'(r_s1);
                    r_xa <= 64'(r_nr[8]) <<< 16;
                    r_state <= S_E2;
                end
                S_E2: r_state <= S_E2W;
                S_E2W: if (c_done) begin
                    r_e2 <= c_out_ang;
                    r_state <= S_P3;
                end
                S_P3: begin
                    r_ya <= -(64'(r_nr[0]) * 64'(r_s1)) + 64'(r_nr[3]) * 64'(r_c1);
                    r_xa <= -(64'(r_nr[1]) * 64'(r_s1)) + 64'(r_nr[4]) * 64'(r_c1);
                    r_state <= S_E3;
                end
                S_E3: r_state <= S_E3W;
                S_E3W: if (c_done) begin
                    r_e3 <= c_out_ang;
                    r_state <= S_OUT;
                end
                S_OUT: if (!o_valid || i_ready) begin
                    o_valid <= 1'b1;
                    o_pos_x <= r_np[0];
                    o_pos_y <= r_np[1];
                    o_pos_z <= r_np[2];
                    o_euler_first <= r_e1[14:0];
                    o_euler_second <= r_e2;
                    o_euler_third <= r_e3;
                    o_saturated <= r_ovf;
                    r_ovf <= 1'b0;
                    for (int i = 0; i < 9; i++) begin
                        r_rot[i] <= (i % 4 == 0) ? dhfk_pkg::ONE_Q16 : 18'sd0;
                    end
                    for (int i = 0; i < 3; i++) r_tr[i] <= '0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- rtl/dh_forward_kinematics_core.sv -----
// Top level of the DH forward kinematics core: link queue plus kinematics engine.
// Depends on dhfk_pkg, dhfk_queue, dhfk_engine.
//
// Channel   Direction  Handshake            Payload
// link in   input      i_valid / o_ready    theta, alpha, a, d, last flag
// pose out  output     o_valid / i_ready    x, y, z, three ZYZ angles, saturated flag
//
// A link's time in the engine is set by the shared CORDIC, run for theta and then
// alpha, and by the single multiplier of the transform product; a last link then also
// runs the Euler angle extraction on the same CORDIC.
// Reset is synchronous, active low, and sets the transform to identity.
// The two-entry queue keeps taking links, up to two, while the engine works or a pose waits.
`default_nettype none
module dh_forward_kinematics_core #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire signed [15:0]   i_joint_angle,
    input  wire signed [15:0]   i_link_twist,
    input  wire signed [23:0]   i_link_length,
    input  wire signed [23:0]   i_link_offset,
    input  wire                 i_last_link,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic signed [31:0]  o_pos_x,
    output logic signed [31:0]  o_pos_y,
    output logic signed [31:0]  o_pos_z,
    output logic signed [14:0]  o_euler_first,
    output logic signed [15:0]  o_euler_second,
    output logic signed [15:0]  o_euler_third,
    output logic                o_saturated
);
    dhfk_pkg::t_link w_in, w_q;
    logic w_qv, w_qr;

    assign w_in = '{theta: i_joint_angle, alpha: i_link_twist, len: i_link_length,
                    ofs: i_link_offset, last: i_last_link};

    dhfk_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_link(w_in), .o_valid(w_qv), .i_ready(w_qr), .o_link(w_q)
    );

    dhfk_engine #(.STEPS(CORDIC_STEPS)) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_qv), .o_ready(w_qr), .i_link(w_q),
        .o_valid(o_valid), .i_ready(i_ready), .o_pos_x(o_pos_x), .o_pos_y(o_pos_y),
        .o_pos_z(o_pos_z), .o_euler_first(o_euler_first),
        .o_euler_second(o_euler_second), .o_euler_third(o_euler_third),
        .o_saturated(o_saturated)
    );

`ifndef SYNTHESIS
    // The folded first angle stays within plus or minus pi/2.
    a_e1_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_euler_first <= 15'sd12868 && o_euler_first >= -15'sd12868))
        else $error("euler_first out of range");
    // A pose waiting on the output stays valid and holds its x and z position.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_pos_x) && $stable(o_pos_z)))
        else $error("pose changed while stalled");
`endif
endmodule
`default_nettype wire

// ----- verif/dh_forward_kinematics_core_tb.sv -----
// Self-checking testbench for dh_forward_kinematics_core: link chains in, end-effector poses out.
// Depends on dhfk_pkg (link type) and the core RTL; holds its own fixed-point pose predictor.
`timescale 1ns / 1ps
`default_nettype none
module dh_forward_kinematics_core_tb;

    localparam int       STEPS       = 16;
    localparam longint   ANG_PI      = 25736;
    localparam longint   ANG_HALF_PI = 12868;
    localparam longint   ACC_PI      = 52707179;
    localparam longint   UNIT        = 65536;
    localparam longint   CORDIC_GAIN = 652032875;
    localparam int       WATCHDOG    = 20000;
    localparam int       NUM_RANDOM  = 1310;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [14:0] first;
        logic signed [15:0] second;
        logic signed [15:0] third;
        logic               sat;
    } t_pose;

    // Directed row: a link, plus a typed pose where it is obvious by inspection.
    typedef struct {
        dhfk_pkg::t_link    link;
        bit                 typed;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               sat;
    } t_row;

    const longint ATAN_TAB[24] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_ready = 1'b0;
    logic signed [15:0] drv_theta = '0;
    logic signed [15:0] drv_alpha = '0;
    logic signed [23:0] drv_len = '0;
    logic signed [23:0] drv_ofs = '0;
    logic drv_last = 1'b0;

    wire in_ready;
    wire out_valid;
    wire signed [31:0] pos_x, pos_y, pos_z;
    wire signed [14:0] eul_first;
    wire signed [15:0] eul_second, eul_third;
    wire saturated;

    dh_forward_kinematics_core #(.CORDIC_STEPS(STEPS)) u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_joint_angle(drv_theta), .i_link_twist(drv_alpha),
        .i_link_length(drv_len), .i_link_offset(drv_ofs), .i_last_link(drv_last),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_pos_x(pos_x), .o_pos_y(pos_y), .o_pos_z(pos_z),
        .o_euler_first(eul_first), .o_euler_second(eul_second),
        .o_euler_third(eul_third), .o_saturated(saturated)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predictor state: running transform of the chain.
    longint chain_rot[9];
    longint chain_pos[3];
    bit     chain_ovf;

    dhfk_pkg::t_link link_queue[$];
    t_pose  pose_queue[$];
    int     links_sent = 0;
    int     link_idx = 0;
    int     mismatches = 0;
    int     quiet_cycles = 0;
    int     sender_idle;
    int     receiver_stall;

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Rotation-mode CORDIC with quadrant fold.
    function automatic void trig(input longint ang, output longint c, output longint s);
        longint x, y, z, nx, ny;
        bit     neg;
        int     i;
        x = CORDIC_GAIN;
        y = 0;
        neg = 1'b0;
        if (ang > ANG_HALF_PI) begin
            ang -= ANG_PI;
            neg = 1'b1;
        end else if (ang < -ANG_HALF_PI) begin
            ang += ANG_PI;
            neg = 1'b1;
        end
        z = ang * 2048;
        for (i = 0; i < STEPS && i < 24; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= ATAN_TAB[i];
            end else begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += ATAN_TAB[i];
            end
            x = nx;
            y = ny;
        end
        x = clip(round_shift(x, 14), -UNIT, UNIT);
        y = clip(round_shift(y, 14), -UNIT, UNIT);
        c = neg ? -x : x;
        s = neg ? -y : y;
    endfunction

    // Vectoring-mode CORDIC atan2, early exit once y reaches zero.
    function automatic longint arctan2(longint y, longint x);
        longint z, nx, ny;
        int     i;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? ACC_PI : -ACC_PI;
            x = -x;
            y = -y;
        end
        for (i = 0; i < STEPS && i < 24; i++) begin
            if (y == 0) break;
            if (y > 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += ATAN_TAB[i];
            end else begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= ATAN_TAB[i];
            end
            x = nx;
            y = ny;
        end
        return clip(round_shift(z, 11), -ANG_PI, ANG_PI);
    endfunction

    function automatic void chain_clear();
        for (int i = 0; i < 9; i++) chain_rot[i] = (i % 4 == 0) ? UNIT : 0;
        for (int i = 0; i < 3; i++) chain_pos[i] = 0;
        chain_ovf = 1'b0;
    endfunction

    // Multiply one link onto the chain; returns 1 with the pose on a last link.
    function automatic bit apply_link(input dhfk_pkg::t_link l, output t_pose p);
        longint ct, st, ca, sa, acc, t, s, e1, e2, e3, c1, s1;
        longint lk[9], pl[3], nr[9], np[3];
        trig(longint'(l.theta), ct, st);
        trig(longint'(l.alpha), ca, sa);
        lk = '{ct, round_shift(-st * ca, 16), round_shift(st * sa, 16),
               st, round_shift(ct * ca, 16), round_shift(-ct * sa, 16),
               0, sa, ca};
        pl = '{round_shift(longint'(l.len) * ct, 16), round_shift(longint'(l.len) * st, 16),
               longint'(l.ofs)};
        for (int i = 0; i < 3; i++) begin
            acc = chain_pos[i] * UNIT;
            for (int k = 0; k < 3; k++) acc += chain_rot[i*3+k] * pl[k];
            t = round_shift(acc, 16);
            np[i] = clip(t, -64'sd2147483648, 64'sd2147483647);
            if (np[i] != t) chain_ovf = 1'b1;
            for (int j = 0; j < 3; j++) begin
                s = 0;
                for (int k = 0; k < 3; k++) s += chain_rot[i*3+k] * lk[k*3+j];
                nr[i*3+j] = clip(round_shift(s, 16), -131072, 131071);
            end
        end
        chain_rot = nr;
        chain_pos = np;
        if (!l.last) return 1'b0;
        e1 = arctan2(nr[5] * UNIT, nr[2] * UNIT);
        if (e1 > ANG_HALF_PI) e1 -= ANG_PI;
        else if (e1 < -ANG_HALF_PI) e1 += ANG_PI;
        trig(e1, c1, s1);
        e2 = arctan2(nr[2] * c1 + nr[5] * s1, nr[8] * UNIT);
        e3 = arctan2(-nr[0] * s1 + nr[3] * c1, -nr[1] * s1 + nr[4] * c1);
        p.x = np[0];
        p.y = np[1];
        p.z = np[2];
        p.first = e1;
        p.second = e2;
        p.third = e3;
        p.sat = chain_ovf;
        chain_clear();
        return 1'b1;
    endfunction

    // Queue a link for the driver and record the pose it should produce.
    function automatic void queue_link(dhfk_pkg::t_link l);
        t_pose p;
        link_queue.push_back(l);
        if (apply_link(l, p)) pose_queue.push_back(p);
    endfunction

    function automatic logic signed [15:0] rand_angle();
        return 16'($signed($urandom_range(2 * ANG_PI)) - ANG_PI);
    endfunction

    function automatic logic signed [23:0] rand_length();
        logic signed [23:0] v;
        v = 24'($urandom);
        // Mostly arm-sized lengths, sometimes the full range.
        return ($urandom_range(3) == 0) ? v : (v >>> 4);
    endfunction

    function automatic dhfk_pkg::t_link rand_link(bit last);
        dhfk_pkg::t_link l;
        l.theta = rand_angle();
        l.alpha = rand_angle();
        l.len = rand_length();
        l.ofs = rand_length();
        l.last = last;
        return l;
    endfunction

    // Directed stimulus: field extremes, sin/cos fold boundaries, chains.
    t_row dir_rows[] = '{
        '{'{16'sd0, 16'sd0, 24'sd0, 24'sd0, 1'b1}, 1'b1, 0, 0, 0, 1'b0},
        '{'{16'sd0, 16'sd0, 24'sd0, 24'sd8388607, 1'b1}, 1'b1, 0, 0, 8388607, 1'b0},
        '{'{16'sd0, 16'sd0, 24'sd0, -24'sd8388608, 1'b1}, 1'b1, 0, 0, -8388608, 1'b0},
        '{'{16'sd25736, 16'sd0, 24'sd8388607, 24'sd0, 1'b1}, 1'b0, 0, 0, 0, 1'b0},
        '{'{-16'sd25736, 16'sd0, -24'sd8388608, 24'sd0, 1'b1}, 1'b0, 0, 0, 0, 1'b0},
        '{'{16'sd0, 16'sd25736, 24'sd65536, 24'sd65536, 1'b1}, 1'b0, 0, 0, 0, 1'b0},
        '{'{16'sd0, -16'sd25736, 24'sd65536, -24'sd65536, 1'b1}, 1'b0, 0, 0, 0, 1'b0},
        '{'{16'sd12868, 16'sd12868, 24'sd65536, 24'sd0, 1'b1}, 1'b0, 0, 0, 0, 1'b0},
        '{'{16'sd12869, -16'sd12869, 24'sd65536, 24'sd0, 1'b1}, 1'b0, 0, 0, 0, 1'b0},
        '{'{-16'sd12868, -16'sd12868, 24'sd32768, 24'sd32768, 1'b1}, 1'b0, 0, 0, 0, 1'b0},
        '{'{-16'sd12869, 16'sd12869, 24'sd32768, 24'sd32768, 1'b1}, 1'b0, 0, 0, 0, 1'b0},
        '{'{16'sd6434, 16'sd12868, 24'sd65536, 24'sd13107, 1'b0}, 1'b0, 0, 0, 0, 1'b0},
        '{'{-16'sd6434, 16'sd0, 24'sd45000, 24'sd0, 1'b0}, 1'b0, 0, 0, 0, 1'b0},
        '{'{16'sd3000, -16'sd12868, 24'sd0, 24'sd20000, 1'b1}, 1'b0, 0, 0, 0, 1'b0},
        '{'{16'sd25736, 16'sd25736, 24'sd8388607, 24'sd8388607, 1'b0}, 1'b0, 0, 0, 0, 1'b0},
        '{'{-16'sd25736, -16'sd25736, -24'sd8388608, -24'sd8388608, 1'b1}, 1'b0, 0, 0, 0, 1'b0},
        '{'{16'sd1, -16'sd1, 24'sd1, -24'sd1, 1'b1}, 1'b0, 0, 0, 0, 1'b0},
        '{'{16'sd0, 16'sd12868, 24'sd0, 24'sd0, 1'b1}, 1'b0, 0, 0, 0, 1'b0}
    };

    // Build all stimulus and the matching poses up front.
    initial begin
        t_pose p;
        int    chain_len;
        chain_clear();
        foreach (dir_rows[r]) begin
            link_queue.push_back(dir_rows[r].link);
            if (apply_link(dir_rows[r].link, p)) begin
                if (dir_rows[r].typed) begin
                    p.x = dir_rows[r].x;
                    p.y = dir_rows[r].y;
                    p.z = dir_rows[r].z;
                    p.sat = dir_rows[r].sat;
                end
                pose_queue.push_back(p);
            end
        end
        // Two long straight chains drive the position into saturation.
        for (int c = 0; c < 2; c++)
            for (int n = 0; n < 260; n++)
                queue_link('{16'sd0, 16'sd0, 24'sd0,
                             c ? -24'sd8388608 : 24'sd8388607, n == 259});
        // Random chains, mostly short arms, a few long ones.
        while (link_queue.size() < NUM_RANDOM + dir_rows.size() + 520) begin
            chain_len = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
            for (int n = 0; n < chain_len; n++) queue_link(rand_link(n == chain_len - 1));
        end
    end

    // Idling profile follows progress through the link list.
    always_comb begin
        case (links_sent * 4 / ((link_queue.size() == 0) ? 1 : link_queue.size()))
            0: begin sender_idle = 0;  receiver_stall = 0;  end
            1: begin sender_idle = 49; receiver_stall = 0;  end
            2: begin sender_idle = 0;  receiver_stall = 49; end
            default: begin sender_idle = 21; receiver_stall = 21; end
        endcase
    end

    // Link driver: holds valid and payload until accepted.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) links_sent <= links_sent + 1;
            if (!in_valid || in_ready) begin
                if (link_idx < link_queue.size() && $urandom_range(99) >= sender_idle) begin
                    drv_theta <= link_queue[link_idx].theta;
                    drv_alpha <= link_queue[link_idx].alpha;
                    drv_len <= link_queue[link_idx].len;
                    drv_ofs <= link_queue[link_idx].ofs;
                    drv_last <= link_queue[link_idx].last;
                    link_idx <= link_idx + 1;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Pose receiver and checker.
    always @(posedge clk) begin
        t_pose e;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= receiver_stall);
            if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (out_valid && out_ready) begin
                if (pose_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected pose at %0t", $realtime);
                end else begin
                    e = pose_queue.pop_front();
                    if (pos_x !== e.x || pos_y !== e.y || pos_z !== e.z ||
                        eul_first !== e.first || eul_second !== e.second ||
                        eul_third !== e.third || saturated !== e.sat) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"pose mismatch at %0t: exp %0d %0d %0d %0d %0d %0d %0b,",
                                      " got %0d %0d %0d %0d %0d %0d %0b"},
                                     $realtime, e.x, e.y, e.z, e.first, e.second, e.third,
                                     e.sat, pos_x, pos_y, pos_z, eul_first, eul_second,
                                     eul_third, saturated);
                    end
                end
            end
        end
    end

    // Watchdog: too long without any handshake.
    always @(posedge clk) begin
        if (quiet_cycles >= WATCHDOG) begin
            $display("dh_forward_kinematics_core regression: fail");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        wait (link_queue.size() > 0 && links_sent == link_queue.size());
        wait (pose_queue.size() == 0);
        repeat (400) @(posedge clk);
        if (mismatches == 0 && pose_queue.size() == 0)
            $display("dh_forward_kinematics_core regression: pass");
        else
            $display("dh_forward_kinematics_core regression: fail");
        $finish;
    end

endmodule
`default_nettype wire
